### rtl/midi_track_event_validator_core_macros.svh
// ---------------------------------------------------------------------------
// MIDI track event validator assertion macros
// Shared property shorthands for the port checker.
// ---------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_VALIDATOR_CORE_MACROS_SVH
`define MIDI_TRACK_EVENT_VALIDATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MTEV_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtev check failed");

// Next-cycle implication, disabled during reset
`define MTEV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtev check failed");

`endif

### rtl/mtev_pkg.sv
// ---------------------------------------------------------------------------
// mtev_pkg
// Types, codes and helpers shared by the MIDI track event validator.
// ---------------------------------------------------------------------------
package mtev_pkg;

  // Parse phase of the current event
  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_STATUS = 3'd1,
    PH_CHAN   = 3'd2,
    PH_MTYPE  = 3'd3,
    PH_LEN    = 3'd4,
    PH_PAY    = 3'd5
  } phase_t;

  // Event kinds
  localparam logic [2:0] KIND_CHAN   = 3'd0;
  localparam logic [2:0] KIND_META   = 3'd1;
  localparam logic [2:0] KIND_SYX_F0 = 3'd2;
  localparam logic [2:0] KIND_SYX_F7 = 3'd3;
  localparam logic [2:0] KIND_BAD    = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_DELTA  = 3'd1;
  localparam logic [2:0] ERR_EXCEEDS    = 3'd2;
  localparam logic [2:0] ERR_BAD_STATUS = 3'd3;
  localparam logic [2:0] ERR_HDR_OVF    = 3'd4;
  localparam logic [2:0] ERR_BAD_LEN    = 3'd5;
  localparam logic [2:0] ERR_LEN_OVF    = 3'd6;

  // Status bytes and nibbles
  localparam logic [7:0] ST_SYX_F0  = 8'hF0;
  localparam logic [7:0] ST_SYX_F7  = 8'hF7;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [3:0] HI_PROG    = 4'hC;
  localparam logic [3:0] HI_CHPRESS = 4'hD;
  localparam logic [3:0] HI_SYSTEM  = 4'hF;

  // Longest variable-length quantity in bytes
  localparam logic [2:0] VLQ_MAX = 3'd4;

  // Field widths
  localparam int unsigned VAL_W  = 28;
  localparam int unsigned SIZE_W = 29;

  // Parse state carried from byte to byte
  typedef struct packed {
    phase_t            phase;
    logic [7:0]        kept_status;
    logic [VAL_W-1:0]  delta_accum;
    logic [2:0]        vlq_count;
    logic [VAL_W-1:0]  length_accum;
    logic [VAL_W-1:0]  bytes_left;
    logic [SIZE_W-1:0] size_count;
    logic [2:0]        kind_held;
  } mtev_state_t;

  // One result item
  typedef struct packed {
    logic [2:0]        kind;
    logic [2:0]        err;
    logic [VAL_W-1:0]  delta;
    logic [SIZE_W-1:0] bytes;
    logic [7:0]        rs;
  } mtev_result_t;

  // Channel voice status: top bit set, not a system message
  function automatic logic is_chan_status(input logic [7:0] s);
    return s[7] && (s[7:4] != HI_SYSTEM);
  endfunction

endpackage

### rtl/mtev_step.sv
// ---------------------------------------------------------------------------
// mtev_step
// Single-byte parse step: next parse state and the optional result item.
// ---------------------------------------------------------------------------
module mtev_step (
  input  mtev_pkg::mtev_state_t  cur,
  input  logic [7:0]             track_byte,
  input  logic                   buffer_end,
  output mtev_pkg::mtev_state_t  nxt,
  output logic                   fire,
  output mtev_pkg::mtev_result_t res
);
  import mtev_pkg::*;

  logic [7:0]        st;
  logic              one_data;
  logic [1:0]        n_data;
  logic [SIZE_W-1:0] size_inc;
  logic [VAL_W-1:0]  bytes_dec;
  logic [VAL_W-1:0]  shift_accum_d;
  logic [VAL_W-1:0]  shift_accum_l;
  logic [2:0]        cnt_inc;

  // Effective status: explicit byte or kept channel running status
  always_comb begin
    if (track_byte[7]) begin
      st = track_byte;
    end else if (is_chan_status(cur.kept_status)) begin
      st = cur.kept_status;
    end else begin
      st = 8'h00;
    end
  end

  // Program change and channel pressure carry one data byte
  assign one_data = (st[7:4] == HI_PROG) || (st[7:4] == HI_CHPRESS);
  assign n_data   = track_byte[7] ? (one_data ? 2'd1 : 2'd2)
                                  : (one_data ? 2'd0 : 2'd1);

  assign size_inc      = cur.size_count + SIZE_W'(1);
  assign bytes_dec     = cur.bytes_left - VAL_W'(1);
  assign shift_accum_d = {cur.delta_accum[VAL_W-8:0], track_byte[6:0]};
  assign shift_accum_l = {cur.length_accum[VAL_W-8:0], track_byte[6:0]};
  assign cnt_inc       = cur.vlq_count + 3'd1;

  // Phase decode and result forming
  always_comb begin
    logic       do_finish;
    logic       do_fail;
    logic [2:0] fail_code;

    do_finish = 1'b0;
    do_fail   = 1'b0;
    fail_code = ERR_NONE;
    nxt            = cur;
    nxt.size_count = size_inc;

    unique case (cur.phase) inside
      PH_STATUS: begin
        if (is_chan_status(st)) begin
          nxt.kind_held   = KIND_CHAN;
          nxt.kept_status = st;
          if (n_data == 2'd0) begin
            do_finish = 1'b1;
          end else if (buffer_end) begin
            do_fail   = 1'b1;
            fail_code = ERR_EXCEEDS;
          end else begin
            nxt.bytes_left = VAL_W'(n_data);
            nxt.phase      = PH_CHAN;
          end
        end else if (st == ST_META) begin
          nxt.kind_held   = KIND_META;
          nxt.kept_status = 8'h00;
          if (buffer_end) begin
            do_fail   = 1'b1;
            fail_code = ERR_HDR_OVF;
          end else begin
            nxt.phase = PH_MTYPE;
          end
        end else if ((st == ST_SYX_F0) || (st == ST_SYX_F7)) begin
          nxt.kind_held   = (st == ST_SYX_F0) ? KIND_SYX_F0 : KIND_SYX_F7;
          nxt.kept_status = 8'h00;
          if (buffer_end) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_LEN;
          end else begin
            nxt.vlq_count    = 3'd0;
            nxt.length_accum = '0;
            nxt.phase        = PH_LEN;
          end
        end else begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_STATUS;
        end
      end
      PH_CHAN, PH_PAY: begin
        nxt.bytes_left = bytes_dec;
        if (bytes_dec == '0) begin
          do_finish = 1'b1;
        end else if (buffer_end) begin
          do_fail   = 1'b1;
          fail_code = (cur.phase == PH_CHAN) ? ERR_EXCEEDS : ERR_LEN_OVF;
        end
      end
      PH_MTYPE: begin
        if (buffer_end) begin
          do_fail   = 1'b1;
          fail_code = ERR_BAD_LEN;
        end else begin
          nxt.vlq_count    = 3'd0;
          nxt.length_accum = '0;
          nxt.phase        = PH_LEN;
        end
      end
      PH_LEN: begin
        nxt.length_accum = shift_accum_l;
        nxt.vlq_count    = cnt_inc;
        if (track_byte[7]) begin
          if ((cnt_inc >= VLQ_MAX) || buffer_end) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_LEN;
          end
        end else if (shift_accum_l == '0) begin
          do_finish = 1'b1;
        end else if (buffer_end) begin
          do_fail   = 1'b1;
          fail_code = ERR_LEN_OVF;
        end else begin
          nxt.bytes_left = shift_accum_l;
          nxt.phase      = PH_PAY;
        end
      end
      default: begin
        // Delta time; unused phase codes land here too
        nxt.delta_accum = shift_accum_d;
        nxt.vlq_count   = cnt_inc;
        nxt.phase       = PH_DELTA;
        if (track_byte[7]) begin
          if ((cnt_inc >= VLQ_MAX) || buffer_end) begin
            do_fail   = 1'b1;
            fail_code = ERR_BAD_DELTA;
          end
        end else if (buffer_end) begin
          do_fail   = 1'b1;
          fail_code = ERR_EXCEEDS;
        end else begin
          nxt.vlq_count = 3'd0;
          nxt.phase     = PH_STATUS;
        end
      end
    endcase

    // Result item
    fire = do_finish || do_fail;
    if (do_fail) begin
      res.kind  = KIND_BAD;
      res.err   = fail_code;
      res.delta = '0;
      res.bytes = '0;
      res.rs    = 8'h00;
    end else begin
      res.kind  = nxt.kind_held;
      res.err   = ERR_NONE;
      res.delta = nxt.delta_accum;
      res.bytes = size_inc;
      res.rs    = nxt.kept_status;
    end

    // Event done: start over at the next delta time
    if (fire) begin
      if (do_fail) begin
        nxt.kept_status = 8'h00;
      end
      nxt.phase        = PH_DELTA;
      nxt.delta_accum  = '0;
      nxt.vlq_count    = 3'd0;
      nxt.length_accum = '0;
      nxt.bytes_left   = '0;
      nxt.size_count   = '0;
      nxt.kind_held    = KIND_CHAN;
    end
  end

endmodule

### rtl/midi_track_event_validator_core.sv
// ---------------------------------------------------------------------------
// midi_track_event_validator_core: one track byte per cycle unless a blocked result stalls it, event results out.
// Path: each byte goes through the input register and the combinational parse step into the result register.
// Throughput: one byte per cycle while the result register is not blocked.
// Reset: synchronous; parse state and running status clear, no result pending.
// ---------------------------------------------------------------------------
module midi_track_event_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] track_byte,
  input  logic       buffer_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_kind,
  output logic [2:0] error_code,
  output logic [mtev_pkg::VAL_W-1:0]  delta_time,
  output logic [mtev_pkg::SIZE_W-1:0] event_bytes,
  output logic [7:0] new_running_status
);
  import mtev_pkg::*;

  logic         in_full;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         advance;
  logic         fire;
  mtev_state_t  state;
  mtev_state_t  state_next;
  mtev_result_t res_next;
  mtev_result_t res;

  // Step stalls only when it has a result and the output slot is blocked
  assign advance  = in_full && (!fire || !out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= track_byte;
      in_last <= buffer_end;
    end
  end

  mtev_step u_step (
    .cur        (state),
    .track_byte (in_byte),
    .buffer_end (in_last),
    .nxt        (state_next),
    .fire       (fire),
    .res        (res_next)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_DELTA;
      state.kept_status  <= 8'h00;
      state.delta_accum  <= '0;
      state.vlq_count    <= 3'd0;
      state.length_accum <= '0;
      state.bytes_left   <= '0;
      state.size_count   <= '0;
      state.kind_held    <= KIND_CHAN;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      res <= res_next;
    end
  end

  assign event_kind         = res.kind;
  assign error_code         = res.err;
  assign delta_time         = res.delta;
  assign event_bytes        = res.bytes;
  assign new_running_status = res.rs;

endmodule

### rtl/mtev_checker.sv
// ---------------------------------------------------------------------------
// mtev_checker
// Port-level checks on the result channel of the event validator.
// ---------------------------------------------------------------------------
`include "midi_track_event_validator_core_macros.svh"

module mtev_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_kind,
  input logic [2:0] error_code,
  input logic [mtev_pkg::VAL_W-1:0]  delta_time,
  input logic [mtev_pkg::SIZE_W-1:0] event_bytes,
  input logic [7:0] new_running_status
);
  import mtev_pkg::*;

  logic ok_evt;

  assign ok_evt = out_valid && (error_code == ERR_NONE);

  // A held result keeps its kind, error code, byte count and running status
  `MTEV_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(event_kind) && $stable(error_code) && $stable(event_bytes) && $stable(new_running_status))

  // Errors are reported as an invalid event with all values cleared
  `MTEV_ASSERT_NOW(a_err_clean, clk, rst, out_valid && (error_code != ERR_NONE), (event_kind == KIND_BAD) && (delta_time == '0) && (event_bytes == '0) && (new_running_status == 8'h00))

  // A good event has a valid kind and at least two bytes
  `MTEV_ASSERT_NOW(a_ok_shape, clk, rst, ok_evt, (event_kind != KIND_BAD) && (event_kind <= KIND_SYX_F7) && (event_bytes >= SIZE_W'(2)))

  // Meta and sysex events drop running status
  `MTEV_ASSERT_NOW(a_rs_cleared, clk, rst, ok_evt && (event_kind != KIND_CHAN), new_running_status == 8'h00)

  // Channel events leave a channel status as running status
  `MTEV_ASSERT_NOW(a_rs_chan, clk, rst, ok_evt && (event_kind == KIND_CHAN), is_chan_status(new_running_status))

endmodule

bind midi_track_event_validator_core mtev_checker u_mtev_checker (.*);
